// ===== rtl/dds_pkg.sv =====
`timescale 1ns / 1ps

package dds_pkg;

   // field widths of the request, response and csr
   localparam int ACT_W    = 2;
   localparam int VTX_W    = 6;
   localparam int DIST_W   = 17;
   localparam int VCOUNT_W = 7;

   // default graph size
   localparam int MAX_VERTICES_DEF = 64;

   // weight that stands for "no edge" / "unreached"
   localparam logic [DIST_W-1:0] NO_EDGE = 17'd100000;

   // vertex_count after reset
   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

   // request action codes
   typedef enum logic [ACT_W-1:0] {
      ACT_WRITE = 2'd0,
      ACT_RUN   = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_INIT,
      ST_SCAN,
      ST_DRAIN,
      ST_VISIT,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

   // relax unit result for one scanned vertex
   typedef struct packed {
      logic              upd;
      logic              better;
      logic [DIST_W-1:0] relaxed_len;
   } relax_type;

endpackage

// ===== rtl/dds_if.sv =====
`timescale 1ns / 1ps

// request channel: edge write, run, clear
interface dds_req_if import dds_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [VTX_W-1:0]  from_vertex;
   logic [VTX_W-1:0]  to_vertex;
   logic [DIST_W-1:0] weight;

   modport source (output valid, action, from_vertex, to_vertex, weight, input ready);
   modport sink   (input valid, action, from_vertex, to_vertex, weight, output ready);
endinterface

// response channel: one distance per vertex
interface dds_rsp_if import dds_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [VTX_W-1:0]  vertex;
   logic [DIST_W-1:0] distance;
   logic              last;

   modport source (output valid, vertex, distance, last, input ready);
   modport sink   (input valid, vertex, distance, last, output ready);
endinterface

// ===== rtl/dds_ram.sv =====
`timescale 1ns / 1ps

// simple dual-port RAM, one write and one registered read per cycle
module dds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/dds_relax.sv =====
`timescale 1ns / 1ps

// relax one unvisited vertex through the current vertex and test it
// against the running minimum
module dds_relax import dds_pkg::*; (
   input  logic [DIST_W-1:0] base,
   input  logic [DIST_W-1:0] weight,
   input  logic [DIST_W-1:0] cur_len,
   input  logic              visited,
   input  logic [DIST_W-1:0] best,
   output relax_type         result
);

   logic [DIST_W:0]   cand;
   logic              upd;
   logic [DIST_W-1:0] relaxed_len;

   // candidate path length, one bit wider so it cannot wrap
   assign cand        = {1'b0, base} + {1'b0, weight};
   assign upd         = !visited && (cand < {1'b0, cur_len});
   assign relaxed_len = upd ? cand[DIST_W-1:0] : cur_len;

   // strict compare keeps the lowest index on ties
   assign result.upd         = upd;
   assign result.relaxed_len = relaxed_len;
   assign result.better      = !visited && (relaxed_len < best);

endmodule

// ===== rtl/dense_dijkstra_shortest_paths_top.sv =====
`timescale 1ns / 1ps
// Edge write: one request per cycle while idle. Clear: a sweep over the WDEPTH
// entries (4096 at 64) of the weight RAM, one entry per cycle, no requests taken.
// Run with n vertices: an init pass over the n distances, up to n-1 rounds of a
// scan (one weight RAM read per scanned vertex), a drain and a visit, then a read
// and a load step per response. Reset (synchronous, active high) starts the same
// clearing sweep; vertex_count returns to 64. One request is worked on at a time.

module dense_dijkstra_shortest_paths_top import dds_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   dds_req_if.sink             req_chan,
   dds_rsp_if.source           rsp_chan,
   input  logic                csr_we,
   input  logic [VCOUNT_W-1:0] csr_wdata
);

   localparam int VW     = $clog2(MAX_VERTICES);
   localparam int WAW    = 2 * VW;
   localparam int WDEPTH = 1 << WAW;

   state_type           state_ff, state_in;
   logic [WAW-1:0]      clr_ff, clr_in;
   logic [VW-1:0]       j_ff, j_in;
   logic [VW-1:0]       r_ff, r_in;
   logic [VW-1:0]       pj_ff, pj_in;
   logic                pvalid_ff, pvalid_in;
   logic [VW-1:0]       cur_ff, cur_in;
   logic [DIST_W-1:0]   base_ff, base_in;
   logic [DIST_W-1:0]   best_ff, best_in;
   logic [VW-1:0]       pick_ff, pick_in;
   logic                found_ff, found_in;
   logic [VCOUNT_W-1:0] vcount_ff, vcount_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VTX_W-1:0]    rsp_vertex_ff, rsp_vertex_in;
   logic [DIST_W-1:0]   rsp_dist_ff, rsp_dist_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                w_we;
   logic [WAW-1:0]      w_waddr;
   logic [DIST_W-1:0]   w_wdata;
   logic [DIST_W-1:0]   w_rdata;
   logic                d_we;
   logic [VW-1:0]       d_waddr;
   logic [DIST_W:0]     d_wdata;
   logic [DIST_W:0]     d_rdata;
   logic                rsp_load;
   logic [VW-1:0]       nm1;
   logic                edge_ok;
   logic [DIST_W-1:0]   sat_weight;
   relax_type           rlx;

   // last vertex index in use: 0 acts as 1, above MAX_VERTICES clamps
   always_comb begin
      if (vcount_ff == '0) begin
         nm1 = '0;
      end else if (vcount_ff > VCOUNT_W'(MAX_VERTICES)) begin
         nm1 = VW'(MAX_VERTICES - 1);
      end else begin
         nm1 = VW'(vcount_ff - VCOUNT_W'(1));
      end
   end

   // edge write checks
   assign edge_ok = ({1'b0, req_chan.from_vertex} < (VTX_W+1)'(MAX_VERTICES)) &&
                    ({1'b0, req_chan.to_vertex} < (VTX_W+1)'(MAX_VERTICES));
   assign sat_weight = (req_chan.weight > NO_EDGE) ? NO_EDGE : req_chan.weight;

   // weight matrix, row = from vertex, column = to vertex
   dds_ram #(
      .WIDTH (DIST_W),
      .DEPTH (WDEPTH)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_waddr),
      .wr_data (w_wdata),
      .rd_addr ({cur_ff, j_ff}),
      .rd_data (w_rdata)
   );

   // per-vertex {visited, distance}
   dds_ram #(
      .WIDTH (DIST_W + 1),
      .DEPTH (MAX_VERTICES)
   ) u_dist_ram (
      .clock   (clock),
      .wr_en   (d_we),
      .wr_addr (d_waddr),
      .wr_data (d_wdata),
      .rd_addr (j_ff),
      .rd_data (d_rdata)
   );

   dds_relax u_relax (
      .base    (base_ff),
      .weight  (w_rdata),
      .cur_len (d_rdata[DIST_W-1:0]),
      .visited (d_rdata[DIST_W]),
      .best    (best_ff),
      .result  (rlx)
   );

   // sequencer: next state, RAM controls, response load
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      j_in          = j_ff;
      r_in          = r_ff;
      pj_in         = pj_ff;
      pvalid_in     = 1'b0;
      cur_in        = cur_ff;
      base_in       = base_ff;
      best_in       = best_ff;
      pick_in       = pick_ff;
      found_in      = found_ff;
      vcount_in     = csr_we ? csr_wdata : vcount_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_last_in   = rsp_last_ff;
      w_we          = 1'b0;
      w_waddr       = {req_chan.from_vertex[VW-1:0], req_chan.to_vertex[VW-1:0]};
      w_wdata       = sat_weight;
      d_we          = 1'b0;
      d_waddr       = pj_ff;
      d_wdata       = {1'b0, rlx.relaxed_len};
      rsp_load      = 1'b0;
      req_chan.ready = (state_ff == ST_IDLE);

      // write back relaxed distance, track minimum
      if (pvalid_ff) begin
         d_we = rlx.upd;
         if (rlx.better) begin
            best_in  = rlx.relaxed_len;
            pick_in  = pj_ff;
            found_in = 1'b1;
         end
      end

      if (rsp_chan.valid && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               case (req_chan.action)
                  ACT_WRITE: begin
                     w_we = edge_ok;
                  end
                  ACT_RUN: begin
                     state_in = ST_INIT;
                     j_in     = '0;
                     cur_in   = '0;
                     base_in  = '0;
                  end
                  ACT_CLEAR: begin
                     state_in = ST_CLEAR;
                     clr_in   = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            w_we    = 1'b1;
            w_waddr = clr_ff;
            w_wdata = NO_EDGE;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_INIT: begin
            // vertex 0 starts visited at distance 0, the rest unreached
            d_we    = 1'b1;
            d_waddr = j_ff;
            d_wdata = (j_ff == '0) ? {1'b1, {DIST_W{1'b0}}} : {1'b0, NO_EDGE};
            if (j_ff == nm1) begin
               j_in = '0;
               if (nm1 == '0) begin
                  state_in = ST_EMIT_RD;
               end else begin
                  state_in = ST_SCAN;
                  r_in     = '0;
                  best_in  = NO_EDGE;
                  found_in = 1'b0;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            pvalid_in = 1'b1;
            pj_in     = j_ff;
            if (j_ff == nm1) begin
               j_in     = '0;
               state_in = ST_DRAIN;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_VISIT;
         end
         ST_VISIT: begin
            if (!found_ff) begin
               state_in = ST_EMIT_RD;
            end else begin
               d_we    = 1'b1;
               d_waddr = pick_ff;
               d_wdata = {1'b1, best_ff};
               cur_in  = pick_ff;
               base_in = best_ff;
               r_in    = r_ff + 1'b1;
               if (VW'(r_ff + 1'b1) == nm1) begin
                  state_in = ST_EMIT_RD;
               end else begin
                  state_in = ST_SCAN;
                  best_in  = NO_EDGE;
                  found_in = 1'b0;
               end
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load      = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = VTX_W'(j_ff);
               rsp_dist_in   = d_rdata[DIST_W-1:0];
               rsp_last_in   = (j_ff == nm1);
               if (j_ff == nm1) begin
                  state_in = ST_IDLE;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pvalid_ff    <= 1'b0;
         vcount_ff    <= VCOUNT_RESET;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pvalid_ff    <= pvalid_in;
         vcount_ff    <= vcount_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      j_ff          <= j_in;
      r_ff          <= r_in;
      pj_ff         <= pj_in;
      base_ff       <= base_in;
      best_ff       <= best_in;
      pick_ff       <= pick_in;
      found_ff      <= found_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.vertex   = rsp_vertex_ff;
   assign rsp_chan.distance = rsp_dist_ff;
   assign rsp_chan.last     = rsp_last_ff;

`ifndef SYNTH
   // a pending response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("pending response overwritten");

   // scan read data is only consumed while a round is scanning
   a_scan_window: assert property (@(posedge clock) disable iff (reset)
      pvalid_ff |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("relax result outside a scan");

   // reported distances never exceed the no-edge value
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_chan.distance <= NO_EDGE))
      else $error("distance out of range");

   // a finished run returns to idle right after its final response is loaded
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_last_in) |=> (state_ff == ST_IDLE))
      else $error("run did not end after final response");
`endif

endmodule
